### rtl/osrld_pkg.sv
`timescale 1ns / 1ps

package osrld_pkg;

   // Widths of the stream and result fields.
   localparam int ByteWidth   = 8;
   localparam int ValueWidth  = 64;
   localparam int CountWidth  = 25;
   localparam int StatusWidth = 3;

   // Dictionary geometry.
   localparam int TableEntries   = 64;
   localparam int TableAddrWidth = $clog2(TableEntries);
   localparam int FillWidth      = 7;
   localparam int ShiftWidth     = 7;
   localparam int IndexWidth     = 6;

   // Token byte layout.
   localparam int ContinueBit = 7;
   localparam int IndexBit    = 6;
   localparam logic [IndexWidth-1:0] EscapeCode = 6'h3f;

   // Reset value of the element limit register.
   localparam logic [CountWidth-1:0] MaxElementsReset = CountWidth'(1 << 23);

   // Status codes on the final result.
   localparam logic [StatusWidth-1:0] StatusOk          = 3'd0;
   localparam logic [StatusWidth-1:0] StatusTableError  = 3'd1;
   localparam logic [StatusWidth-1:0] StatusEscapeError = 3'd2;
   localparam logic [StatusWidth-1:0] StatusTooMany     = 3'd3;
   localparam logic [StatusWidth-1:0] StatusMismatch    = 3'd4;

endpackage

### rtl/osrld_req_if.sv
`timescale 1ns / 1ps

// Compressed byte stream channel.
interface osrld_req_if;
   logic                            valid;
   logic                            ready;
   logic [osrld_pkg::ByteWidth-1:0] in_byte;
   logic                            last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

### rtl/osrld_rsp_if.sv
`timescale 1ns / 1ps

// Decoded run channel.
interface osrld_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              run_present;
   logic [osrld_pkg::ValueWidth-1:0]  run_value;
   logic [osrld_pkg::CountWidth-1:0]  run_length;
   logic                              is_final;
   logic [osrld_pkg::StatusWidth-1:0] status;

   modport source (output valid, output run_present, output run_value, output run_length,
                   output is_final, output status, input ready);
   modport sink   (input valid, input run_present, input run_value, input run_length,
                   input is_final, input status, output ready);
endinterface

### rtl/osrld_csr_if.sv
`timescale 1ns / 1ps

// Element limit register write channel.
interface osrld_csr_if;
   logic                             valid;
   logic                             ready;
   logic [osrld_pkg::CountWidth-1:0] max_elements;

   modport source (output valid, output max_elements, input ready);
   modport sink   (input valid, input max_elements, output ready);
endinterface

### rtl/one_span_run_length_decoder.sv
`timescale 1ns / 1ps

// A byte passes through the input stage register and then the result register. While a
// result waits there untaken, a byte is taken only into an empty input stage, where it waits.
// Throughput: one byte per cycle while results are taken without a stall.
// The single table memory read port is addressed at the byte transfer, so a token is decoded
// in one pass. Reset (synchronous, active high) returns the stream state to the header phase
// and the element limit to 1 << 23; table contents are undefined until written.
module one_span_run_length_decoder (
   input  logic           clock,
   input  logic           reset,
   osrld_req_if.sink      req_ch,
   osrld_rsp_if.source    rsp_ch,
   osrld_csr_if.sink      csr_ch
);

   typedef enum logic [3:0] {
      PhHeader = 4'b0001,
      PhTable  = 4'b0010,
      PhToken  = 4'b0100,
      PhEscape = 4'b1000
   } phase_type;

   // Configuration.
   logic [osrld_pkg::CountWidth-1:0] max_ff;

   // Input stage.
   logic                            s1_valid_ff;
   logic [osrld_pkg::ByteWidth-1:0] s1_byte_ff;
   logic                            s1_last_ff;
   logic [osrld_pkg::ValueWidth-1:0] rd_ff;

   // Dictionary memory.
   logic [osrld_pkg::ValueWidth-1:0] table_mem [osrld_pkg::TableEntries];
   logic                             mem_we;

   // Stream state.
   phase_type                          phase_ff, phase_in;
   logic [osrld_pkg::IndexWidth-1:0]   size_ff, size_in;
   logic [osrld_pkg::FillWidth-1:0]    fill_ff, fill_in;
   logic [osrld_pkg::ValueWidth-1:0]   acc_ff, acc_in;
   logic [osrld_pkg::ShiftWidth-1:0]   shift_ff, shift_in;
   logic                               span_ff, span_in;
   logic [osrld_pkg::CountWidth-1:0]   elem_ff, elem_in;
   logic [osrld_pkg::ValueWidth-1:0]   expected_ff, expected_in;
   logic [osrld_pkg::CountWidth-1:0]   bytes_ff, bytes_in;
   logic                               err_ff, err_in;
   logic [osrld_pkg::StatusWidth-1:0]  code_ff, code_in;

   // Result register.
   logic                              out_valid_ff;
   logic                              out_run_ff;
   logic [osrld_pkg::ValueWidth-1:0]  out_value_ff;
   logic [osrld_pkg::CountWidth-1:0]  out_length_ff;
   logic                              out_final_ff;
   logic [osrld_pkg::StatusWidth-1:0] out_status_ff;

   // Handshake control.
   logic out_free;
   logic process;
   logic req_xfer;

   // Decode signals.
   logic [osrld_pkg::IndexWidth-1:0]  low;
   logic [osrld_pkg::ValueWidth-1:0]  new_acc;
   logic                              feed_bad;
   logic                              feed_done;
   logic [osrld_pkg::ValueWidth-1:0]  tbl_value;
   logic                              dlv_en;
   logic                              dlv_one;
   logic [osrld_pkg::ValueWidth-1:0]  dlv_value;
   logic                              dlv_over;
   logic [osrld_pkg::CountWidth:0]    span_sum;
   logic                              run;
   logic [osrld_pkg::ValueWidth-1:0]  run_value;
   logic [osrld_pkg::CountWidth-1:0]  run_length;
   logic                              emit;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign process      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Configuration register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= osrld_pkg::MaxElementsReset;
      end else if (csr_ch.valid) begin
         max_ff <= csr_ch.max_elements;
      end
   end

   // Input stage holds one byte until the result register can take its outcome.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (process) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_ch.in_byte;
         s1_last_ff <= req_ch.last_byte;
      end
   end

   // Table memory: read at the byte transfer, written when an entry completes.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_ff <= table_mem[req_ch.in_byte[osrld_pkg::TableAddrWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[fill_ff[osrld_pkg::TableAddrWidth-1:0]] <= new_acc;
      end
   end

   // Varint accumulation and token field extraction.
   assign low       = s1_byte_ff[osrld_pkg::IndexWidth-1:0];
   assign new_acc   = acc_ff | (osrld_pkg::ValueWidth'(s1_byte_ff[6:0]) << shift_ff);
   assign feed_bad  = (shift_ff >= osrld_pkg::ShiftWidth'(63) && s1_byte_ff >= 8'd2)
                   || (s1_byte_ff == '0 && shift_ff != '0);
   assign feed_done = !s1_byte_ff[osrld_pkg::ContinueBit];

   // Table lookup: the entry after the last one reads as the expected count.
   always_comb begin
      if (low < size_ff) begin
         if (7'(low) < 7'(osrld_pkg::TableEntries)) begin
            tbl_value = rd_ff;
         end else begin
            tbl_value = '0;
         end
      end else if (low == size_ff) begin
         tbl_value = expected_ff;
      end else begin
         tbl_value = '0;
      end
   end

   // One-pass decode of the byte in the input stage.
   always_comb begin
      phase_in    = phase_ff;
      size_in     = size_ff;
      fill_in     = fill_ff;
      acc_in      = acc_ff;
      shift_in    = shift_ff;
      span_in     = span_ff;
      elem_in     = elem_ff;
      expected_in = expected_ff;
      bytes_in    = bytes_ff;
      err_in      = err_ff;
      code_in     = code_ff;
      mem_we      = 1'b0;
      dlv_en      = 1'b0;
      dlv_one     = 1'b0;
      dlv_value   = '0;
      dlv_over    = 1'b0;
      span_sum    = '0;
      run         = 1'b0;
      run_value   = '0;
      run_length  = '0;

      // Compressed byte limit.
      if (!err_in) begin
         if (bytes_ff >= max_ff) begin
            err_in  = 1'b1;
            code_in = osrld_pkg::StatusTooMany;
         end else begin
            bytes_in = bytes_ff + 1'b1;
         end
      end

      if (!err_in) begin
         unique case (phase_ff)
            PhHeader: begin
               size_in  = low;
               fill_in  = '0;
               acc_in   = '0;
               shift_in = '0;
               phase_in = PhTable;
            end
            PhTable: begin
               if (feed_bad) begin
                  err_in  = 1'b1;
                  code_in = osrld_pkg::StatusTableError;
               end else if (feed_done) begin
                  if (fill_ff < osrld_pkg::FillWidth'(size_ff)) begin
                     mem_we   = process
                             && (fill_ff < osrld_pkg::FillWidth'(osrld_pkg::TableEntries));
                     fill_in  = fill_ff + 1'b1;
                     acc_in   = '0;
                     shift_in = '0;
                  end else begin
                     expected_in = new_acc;
                     if (new_acc[osrld_pkg::ValueWidth-1:osrld_pkg::CountWidth] != '0
                         || new_acc[osrld_pkg::CountWidth-1:0] > max_ff) begin
                        err_in  = 1'b1;
                        code_in = osrld_pkg::StatusTooMany;
                     end else begin
                        phase_in = PhToken;
                     end
                  end
               end else begin
                  acc_in   = new_acc;
                  shift_in = shift_ff + osrld_pkg::ShiftWidth'(7);
               end
            end
            PhToken: begin
               dlv_one = s1_byte_ff[osrld_pkg::ContinueBit];
               if (s1_byte_ff[osrld_pkg::IndexBit]) begin
                  dlv_en    = 1'b1;
                  dlv_value = tbl_value;
               end else if (low != osrld_pkg::EscapeCode) begin
                  dlv_en    = 1'b1;
                  dlv_value = osrld_pkg::ValueWidth'(low);
               end else begin
                  span_in  = dlv_one;
                  acc_in   = '0;
                  shift_in = '0;
                  phase_in = PhEscape;
               end
            end
            PhEscape: begin
               if (feed_bad) begin
                  err_in  = 1'b1;
                  code_in = osrld_pkg::StatusEscapeError;
               end else if (feed_done) begin
                  phase_in  = PhToken;
                  dlv_en    = 1'b1;
                  dlv_one   = span_ff;
                  dlv_value = new_acc;
                  span_in   = 1'b0;
               end else begin
                  acc_in   = new_acc;
                  shift_in = shift_ff + osrld_pkg::ShiftWidth'(7);
               end
            end
            default: begin
               phase_in = PhHeader;
            end
         endcase
      end

      // Deliver a span of ones or a plain value against the element limit.
      if (dlv_en) begin
         if (dlv_one) begin
            dlv_over = dlv_value[osrld_pkg::ValueWidth-1:osrld_pkg::CountWidth] != '0
                    || dlv_value[osrld_pkg::CountWidth-1:0] > max_ff;
            span_sum = {1'b0, dlv_value[osrld_pkg::CountWidth-1:0]} + {1'b0, elem_ff};
            if (dlv_over || span_sum > {1'b0, max_ff}) begin
               err_in  = 1'b1;
               code_in = osrld_pkg::StatusTooMany;
            end else begin
               elem_in = span_sum[osrld_pkg::CountWidth-1:0];
               if (dlv_value != '0) begin
                  run        = 1'b1;
                  run_value  = osrld_pkg::ValueWidth'(1);
                  run_length = dlv_value[osrld_pkg::CountWidth-1:0];
               end
            end
         end else begin
            if (elem_ff >= max_ff) begin
               err_in  = 1'b1;
               code_in = osrld_pkg::StatusTooMany;
            end else begin
               elem_in    = elem_ff + 1'b1;
               run        = 1'b1;
               run_value  = dlv_value;
               run_length = osrld_pkg::CountWidth'(1);
            end
         end
      end

      // End of stream checks.
      if (s1_last_ff && !err_in) begin
         if (phase_in == PhEscape) begin
            err_in  = 1'b1;
            code_in = osrld_pkg::StatusEscapeError;
         end else if (phase_in != PhToken) begin
            err_in  = 1'b1;
            code_in = osrld_pkg::StatusTableError;
         end else if (expected_in != osrld_pkg::ValueWidth'(elem_in)) begin
            err_in  = 1'b1;
            code_in = osrld_pkg::StatusMismatch;
         end
      end
   end

   assign emit = run || s1_last_ff;

   // Stream state registers; the last byte returns them to their reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhHeader;
         size_ff     <= '0;
         fill_ff     <= '0;
         acc_ff      <= '0;
         shift_ff    <= '0;
         span_ff     <= 1'b0;
         elem_ff     <= '0;
         expected_ff <= '0;
         bytes_ff    <= '0;
         err_ff      <= 1'b0;
         code_ff     <= osrld_pkg::StatusOk;
      end else if (process) begin
         if (s1_last_ff) begin
            phase_ff    <= PhHeader;
            size_ff     <= '0;
            fill_ff     <= '0;
            acc_ff      <= '0;
            shift_ff    <= '0;
            span_ff     <= 1'b0;
            elem_ff     <= '0;
            expected_ff <= '0;
            bytes_ff    <= '0;
            err_ff      <= 1'b0;
            code_ff     <= osrld_pkg::StatusOk;
         end else begin
            phase_ff    <= phase_in;
            size_ff     <= size_in;
            fill_ff     <= fill_in;
            acc_ff      <= acc_in;
            shift_ff    <= shift_in;
            span_ff     <= span_in;
            elem_ff     <= elem_in;
            expected_ff <= expected_in;
            bytes_ff    <= bytes_in;
            err_ff      <= err_in;
            code_ff     <= code_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (process && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && emit) begin
         out_run_ff    <= run;
         out_value_ff  <= run_value;
         out_length_ff <= run_length;
         out_final_ff  <= s1_last_ff;
         out_status_ff <= (s1_last_ff && err_in) ? code_in : osrld_pkg::StatusOk;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.run_present = out_run_ff;
   assign rsp_ch.run_value   = out_value_ff;
   assign rsp_ch.run_length  = out_length_ff;
   assign rsp_ch.is_final    = out_final_ff;
   assign rsp_ch.status      = out_status_ff;

   // A final byte leaves the decoder ready for a new header with no error pending.
   a_final_clears : assert property (@(posedge clock) disable iff (reset)
      process && s1_last_ff |=> phase_ff == PhHeader && !err_ff && bytes_ff == '0)
      else $error("stream state not cleared after the final byte");

   // Status is only reported on the result that closes the stream.
   a_status_final : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.is_final |-> rsp_ch.status == osrld_pkg::StatusOk)
      else $error("nonzero status on a result that is not final");

   // A transferred run never has zero length.
   a_run_length : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.run_present |-> rsp_ch.run_length != '0)
      else $error("run with zero length");

   // The table is written only while table entries are decoded.
   a_table_write : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> process && phase_ff == PhTable && !err_ff)
      else $error("table write outside the table phase");

endmodule
